// ----- design/rpn_stack_calculator_macros.svh -----
// ---------------------------------------------------------------------------
// rpn_stack_calculator_macros.svh
// Assertion macros shared by the calculator RTL. Each expects the including
// module to have clock and reset signals in scope.
// ---------------------------------------------------------------------------
`ifndef RPN_STACK_CALCULATOR_MACROS_SVH
`define RPN_STACK_CALCULATOR_MACROS_SVH

// property must hold at every clock edge outside reset
`define RPN_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// condition must never be true outside reset
`define RPN_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

// ----- design/rpn_pkg.sv -----
// ---------------------------------------------------------------------------
// rpn_pkg
// Shared constants, codes and controller/datapath types of the calculator.
// ---------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

   localparam int STACK_DEPTH_DEF = 16;
   localparam int DATA_WIDTH_DEF  = 32;

   localparam int OPCODE_WIDTH    = 3;
   localparam int FIELD_WIDTH     = 32;
   localparam int STATUS_WIDTH    = 3;
   localparam int DEPTH_OUT_WIDTH = 5;

   localparam logic [OPCODE_WIDTH-1:0] OP_PUSH = 3'd0;
   localparam logic [OPCODE_WIDTH-1:0] OP_SUB  = 3'd1;
   localparam logic [OPCODE_WIDTH-1:0] OP_ADD  = 3'd2;
   localparam logic [OPCODE_WIDTH-1:0] OP_MUL  = 3'd3;
   localparam logic [OPCODE_WIDTH-1:0] OP_DIV  = 3'd4;

   localparam logic [STATUS_WIDTH-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_UNDER   = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL    = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_DIVZERO = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] ST_DIVOVF  = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_READ,
      S_WAIT,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic                    capture;
      logic                    push_write;
      logic                    read_left;
      logic                    commit_alu;
      logic                    start_unit;
      logic                    commit_unit;
      logic                    set_status;
      logic [STATUS_WIDTH-1:0] status_code;
      logic                    load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [OPCODE_WIDTH-1:0] opcode;
      logic                    full;
      logic                    short_stack;
      logic                    right_zero;
      logic                    div_ovf;
      logic                    unit_done;
   } flags_type;

endpackage

`default_nettype wire

// ----- design/rpn_if.sv -----
// ---------------------------------------------------------------------------
// rpn_if
// Valid/ready channels of the calculator: request items and response items.
// ---------------------------------------------------------------------------
`default_nettype none

interface rpn_req_if import rpn_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic        [OPCODE_WIDTH-1:0] opcode;
   logic signed [FIELD_WIDTH-1:0]  push_value;

   modport source (output valid, output opcode, output push_value, input ready);
   modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface rpn_rsp_if import rpn_pkg::*; ();
   logic                              valid;
   logic                              ready;
   logic signed [FIELD_WIDTH-1:0]     top_value;
   logic        [STATUS_WIDTH-1:0]    status;
   logic        [DEPTH_OUT_WIDTH-1:0] stack_depth;

   modport source (output valid, output top_value, output status, output stack_depth,
                   input ready);
   modport sink   (input valid, input top_value, input status, input stack_depth,
                   output ready);
endinterface

`default_nettype wire

// ----- design/rpn_ram.sv -----
// ---------------------------------------------------------------------------
// rpn_ram
// Generic RAM: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module rpn_ram import rpn_pkg::*; #(
   parameter int WIDTH = DATA_WIDTH_DEF,
   parameter int DEPTH = STACK_DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- design/rpn_muldiv.sv -----
// ---------------------------------------------------------------------------
// rpn_muldiv
// Iterative multiply (shift-add, low half) and signed divide (restoring,
// truncating), one bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
`include "rpn_stack_calculator_macros.svh"

module rpn_muldiv import rpn_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic                  is_div,
   input  wire logic [DATA_WIDTH-1:0] left,
   input  wire logic [DATA_WIDTH-1:0] right,
   output      logic                  done,
   output      logic [DATA_WIDTH-1:0] result
);

   localparam int CNT_W = $clog2(DATA_WIDTH + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  div_ff, div_in;
   logic                  neg_ff, neg_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic [DATA_WIDTH-1:0] opa_ff, opa_in;
   logic [DATA_WIDTH-1:0] opb_ff, opb_in;

   logic [DATA_WIDTH-1:0] left_mag;
   logic [DATA_WIDTH-1:0] right_mag;
   logic [DATA_WIDTH:0]   rem_shift;
   logic [DATA_WIDTH:0]   diff;
   logic                  take;

   always_comb begin
      left_mag  = left[DATA_WIDTH-1]  ? (~left + 1'b1)  : left;
      right_mag = right[DATA_WIDTH-1] ? (~right + 1'b1) : right;
      rem_shift = {acc_ff, opb_ff[DATA_WIDTH-1]};
      diff      = rem_shift - {1'b0, opa_ff};
      take      = ~diff[DATA_WIDTH];

      busy_in = busy_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      opa_in  = opa_ff;
      opb_in  = opb_ff;
      done_in = busy_ff && (cnt_ff == CNT_W'(1));

      if (start) begin
         busy_in = 1'b1;
         div_in  = is_div;
         neg_in  = left[DATA_WIDTH-1] ^ right[DATA_WIDTH-1];
         cnt_in  = CNT_W'(DATA_WIDTH);
         acc_in  = '0;
         opa_in  = is_div ? right_mag : left;
         opb_in  = is_div ? left_mag  : right;
      end else if (busy_ff) begin
         if (div_ff) begin
            acc_in = take ? diff[DATA_WIDTH-1:0] : rem_shift[DATA_WIDTH-1:0];
            opb_in = {opb_ff[DATA_WIDTH-2:0], take};
         end else begin
            acc_in = acc_ff + (opb_ff[0] ? opa_ff : '0);
            opa_in = {opa_ff[DATA_WIDTH-2:0], 1'b0};
            opb_in = {1'b0, opb_ff[DATA_WIDTH-1:1]};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      div_ff <= div_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
   end

   assign done   = done_ff;
   assign result = div_ff ? (neg_ff ? (~opb_ff + 1'b1) : opb_ff) : acc_ff;

   `RPN_ASSERT_NEVER(a_start_while_busy, start && busy_ff, "unit restarted while busy")
   `RPN_ASSERT_NEVER(a_done_while_busy, done_ff && busy_ff, "done raised during iteration")

endmodule

`default_nettype wire

// ----- design/rpn_dp.sv -----
// ---------------------------------------------------------------------------
// rpn_dp
// Datapath: stack pointer, cached top of stack, stack RAM, add/subtract,
// multiply/divide unit and the response register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "rpn_stack_calculator_macros.svh"

module rpn_dp import rpn_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire cmd_type                           cmd,
   output      flags_type                         flags,
   input  wire logic        [OPCODE_WIDTH-1:0]    req_opcode,
   input  wire logic signed [FIELD_WIDTH-1:0]     req_push_value,
   output      logic signed [FIELD_WIDTH-1:0]     rsp_top_value,
   output      logic        [STATUS_WIDTH-1:0]    rsp_status,
   output      logic        [DEPTH_OUT_WIDTH-1:0] rsp_stack_depth
);

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int PTR_W  = $clog2(STACK_DEPTH + 1);

   logic [PTR_W-1:0]        sp_ff, sp_in;
   logic [DATA_WIDTH-1:0]   top_ff, top_in;
   logic [OPCODE_WIDTH-1:0] opcode_ff;
   logic [DATA_WIDTH-1:0]   value_ff;
   logic [STATUS_WIDTH-1:0] status_ff, status_in;

   logic signed [FIELD_WIDTH-1:0]     rsp_top_ff;
   logic        [STATUS_WIDTH-1:0]    rsp_status_ff;
   logic        [DEPTH_OUT_WIDTH-1:0] rsp_depth_ff;

   logic [PTR_W-1:0]      sp_m2;
   logic [DATA_WIDTH-1:0] left_data;
   logic [DATA_WIDTH-1:0] alu_res;
   logic [DATA_WIDTH-1:0] unit_res;
   logic [DATA_WIDTH-1:0] commit_res;
   logic                  unit_done;
   logic                  commit;
   logic                  ram_we;
   logic [ADDR_W-1:0]     ram_waddr;
   logic [DATA_WIDTH-1:0] ram_wdata;

   assign sp_m2      = sp_ff - PTR_W'(2);
   assign alu_res    = (opcode_ff == OP_SUB) ? (left_data - top_ff) : (left_data + top_ff);
   assign commit_res = cmd.commit_unit ? unit_res : alu_res;
   assign commit     = cmd.commit_alu | cmd.commit_unit;

   assign ram_we    = cmd.push_write | commit;
   assign ram_waddr = cmd.push_write ? sp_ff[ADDR_W-1:0] : sp_m2[ADDR_W-1:0];
   assign ram_wdata = cmd.push_write ? value_ff : commit_res;

   rpn_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (cmd.read_left),
      .raddr (sp_m2[ADDR_W-1:0]),
      .rdata (left_data)
   );

   rpn_muldiv #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start_unit),
      .is_div (opcode_ff == OP_DIV),
      .left   (left_data),
      .right  (top_ff),
      .done   (unit_done),
      .result (unit_res)
   );

   always_comb begin
      sp_in     = sp_ff;
      top_in    = top_ff;
      status_in = status_ff;
      if (cmd.push_write) begin
         sp_in  = sp_ff + PTR_W'(1);
         top_in = value_ff;
      end else if (commit) begin
         sp_in  = sp_ff - PTR_W'(1);
         top_in = commit_res;
      end
      if (cmd.capture) begin
         status_in = ST_OK;
      end else if (cmd.set_status) begin
         status_in = cmd.status_code;
      end
   end

   always_comb begin
      flags.opcode      = opcode_ff;
      flags.full        = (sp_ff == PTR_W'(STACK_DEPTH));
      flags.short_stack = (sp_ff < PTR_W'(2));
      flags.right_zero  = (top_ff == '0);
      flags.div_ovf     = (left_data == {1'b1, {(DATA_WIDTH-1){1'b0}}}) && (top_ff == '1);
      flags.unit_done   = unit_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         sp_ff <= sp_in;
      end
      top_ff    <= top_in;
      status_ff <= status_in;
      if (cmd.capture) begin
         opcode_ff <= req_opcode;
         value_ff  <= DATA_WIDTH'(req_push_value);
      end
      if (cmd.load_rsp) begin
         rsp_top_ff    <= (sp_ff == '0) ? '0 : FIELD_WIDTH'($signed(top_ff));
         rsp_status_ff <= status_ff;
         rsp_depth_ff  <= DEPTH_OUT_WIDTH'(sp_ff);
      end
   end

   assign rsp_top_value   = rsp_top_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_stack_depth = rsp_depth_ff;

   `RPN_ASSERT(a_sp_bound, sp_ff <= PTR_W'(STACK_DEPTH), "stack pointer beyond depth")
   `RPN_ASSERT(a_push_grows, cmd.push_write |=> sp_ff == $past(sp_ff) + PTR_W'(1), "push lost")

endmodule

`default_nettype wire

// ----- design/rpn_ctrl.sv -----
// ---------------------------------------------------------------------------
// rpn_ctrl
// Controller: sequences one item through check, operand read, arithmetic
// and response, and owns the channel handshakes.
// ---------------------------------------------------------------------------
`default_nettype none
`include "rpn_stack_calculator_macros.svh"

module rpn_ctrl import rpn_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   output      logic      req_ready,
   output      logic      rsp_valid,
   input  wire logic      rsp_ready,
   input  wire flags_type flags,
   output      cmd_type   cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            unique case (flags.opcode) inside
               OP_SUB, OP_ADD, OP_MUL: begin
                  state_in = flags.short_stack ? S_RESULT : S_READ;
               end
               OP_DIV: begin
                  state_in = (flags.short_stack || flags.right_zero) ? S_RESULT : S_READ;
               end
               default: begin
                  state_in = S_RESULT;
               end
            endcase
         end
         S_READ: begin
            unique case (flags.opcode) inside
               OP_SUB, OP_ADD: begin
                  state_in = S_RESULT;
               end
               OP_DIV: begin
                  state_in = flags.div_ovf ? S_RESULT : S_WAIT;
               end
               default: begin
                  state_in = S_WAIT;
               end
            endcase
         end
         S_WAIT: begin
            if (flags.unit_done) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
         end
         S_CHECK: begin
            unique case (flags.opcode) inside
               OP_PUSH: begin
                  if (flags.full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_FULL;
                  end else begin
                     cmd.push_write = 1'b1;
                  end
               end
               OP_SUB, OP_ADD, OP_MUL, OP_DIV: begin
                  if (flags.short_stack) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_UNDER;
                  end else if (flags.opcode == OP_DIV && flags.right_zero) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_DIVZERO;
                  end else begin
                     cmd.read_left = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         S_READ: begin
            unique case (flags.opcode) inside
               OP_SUB, OP_ADD: begin
                  cmd.commit_alu = 1'b1;
               end
               OP_DIV: begin
                  if (flags.div_ovf) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_DIVOVF;
                  end else begin
                     cmd.start_unit = 1'b1;
                  end
               end
               default: begin
                  cmd.start_unit = 1'b1;
               end
            endcase
         end
         S_WAIT: begin
            cmd.commit_unit = flags.unit_done;
         end
         S_RESULT: begin
            cmd.load_rsp = slot_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `RPN_ASSERT(a_no_overwrite, cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready), "pending item overwritten")

endmodule

`default_nettype wire

// ----- design/rpn_stack_calculator.sv -----
// ---------------------------------------------------------------------------
// rpn_stack_calculator
// Reverse Polish integer calculator on a bounded stack held in RAM.
// Flow per item: accept, check, then the response for push, no-op and errors
// found at check; add/subtract and divide overflow add an operand read;
// multiply/divide also wait on the one-bit-per-cycle iterative unit.
// One item at a time: a new item is taken only in idle, once the last one's
// response is loaded; loading waits while a prior response awaits rsp ready.
// Synchronous active-high reset empties the stack; the RAM is not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module rpn_stack_calculator import rpn_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   rpn_req_if.sink    req_if,
   rpn_rsp_if.source  rsp_if
);

   cmd_type   cmd;
   flags_type flags;

   rpn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .flags     (flags),
      .cmd       (cmd)
   );

   rpn_dp #(
      .STACK_DEPTH (STACK_DEPTH),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .flags           (flags),
      .req_opcode      (req_if.opcode),
      .req_push_value  (req_if.push_value),
      .rsp_top_value   (rsp_if.top_value),
      .rsp_status      (rsp_if.status),
      .rsp_stack_depth (rsp_if.stack_depth)
   );

endmodule

`default_nettype wire
